/* rtl/mvcb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvcb_pkg
// Shared types and constants of the motion vector cell binning block.
// ----------------------------------------------------------------------------
package mvcb_pkg;

	localparam int XY_W   = 16;
	localparam int CN_W   = 13;
	localparam int CS_W   = 7;
	localparam int GRID_W = 9;
	localparam int SUM_W  = 32;
	localparam int MEAN_W = 8;
	localparam int CRD_W  = 20;
	localparam int IDX_W  = 19;
	localparam int DVD_W  = 33;
	localparam int MAG_W  = 32;
	localparam int DVR_W  = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	localparam logic [CS_W-1:0]   CELL_EDGE_RST = 7'd16;
	localparam logic [GRID_W-1:0] GRID_COLS_RST = 9'd120;
	localparam logic [GRID_W-1:0] GRID_ROWS_RST = 9'd68;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_EDGE,
		REG_GRID_COLUMNS,
		REG_GRID_ROWS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		DIV_C0,
		DIV_R0,
		DIV_C1,
		DIV_R1,
		DIV_MX,
		DIV_MY
	} div_sel_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_WAIT,
		OP_ROW_INIT,
		OP_COL_INIT,
		OP_OVL,
		OP_AREA,
		OP_MUL,
		OP_MRD,
		OP_MWR,
		OP_COL_NEXT,
		OP_ROW_NEXT,
		OP_RRD,
		OP_RCAP,
		OP_RZERO,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_DSTART,
		S_DWAIT,
		S_ROW_INIT,
		S_ROW_CHK,
		S_COL_INIT,
		S_COL_CHK,
		S_OVL,
		S_AREA,
		S_MUL,
		S_MRD,
		S_MWR,
		S_COL_NEXT,
		S_ROW_NEXT,
		S_RRD,
		S_RCAP,
		S_RZERO,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t      op;
		div_sel_t dsel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic row_lt;
		logic col_lt;
		logic cell_ok;
		logic n_ok;
		logic cs_zero;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/motion_vector_cell_binning.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motion_vector_cell_binning
// Bins motion vectors into per-cell area-weighted sums and reads out a cell's
// mean motion, clearing the cell.
// ----------------------------------------------------------------------------
// after reset a clearing pass over all MAX_CELLS cells runs before the first word
// accumulate word: four divisions, then a walk over the covered rows and cells;
// read word: two divisions, or none with nothing to divide; all divisions run on
// the one shared serial divider
// one word is worked on at a time; a result waits in the output register
// reset is asynchronous and clears control state and the registers to defaults
// ----------------------------------------------------------------------------
module motion_vector_cell_binning #(
	parameter int unsigned MAX_CELLS = 8192
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// src_x, src_y, dst_x, dst_y, cell_number, zero fill
	input  wire logic [mvcb_pkg::IN_DATA_W-1:0]       s_tdata,
	// kind
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// mean_motion_x, mean_motion_y
	output logic      [mvcb_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mvcb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mvcb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mvcb_pkg::*;

	logic [CS_W-1:0]   cs_q;
	logic [GRID_W-1:0] gc_q, gr_q;
	cmd_t              cmd;
	stat_t             stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CELL_EDGE_RST;
			gc_q <= GRID_COLS_RST;
			gr_q <= GRID_ROWS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CELL_EDGE:    cs_q <= cfg_data[CS_W-1:0];
				REG_GRID_COLUMNS: gc_q <= cfg_data;
				REG_GRID_ROWS:    gr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mvcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	mvcb_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata),
		.cs       (cs_q),
		.gc       (gc_q),
		.gr       (gr_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_no_input_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CLR |-> !s_tready)
		else $error("input taken during clearing pass");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> stat.out_free)
		else $error("pending result overwritten");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("read word did not start a sequence");

endmodule
`default_nettype wire

/* rtl/mvcb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvcb_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mvcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/mvcb_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvcb_div
// Iterative signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mvcb_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [mvcb_pkg::DVD_W-1:0] dividend,
	input  wire logic [mvcb_pkg::DVR_W-1:0]   divisor,
	output logic                              done,
	output logic signed [mvcb_pkg::DVD_W-1:0] quotient
);
	import mvcb_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] a_q;
	logic [DVR_W-1:0] rem_q;
	logic [DVR_W-1:0] d_q;
	logic             neg_q;
	logic [DVR_W:0]   trial;
	logic             ge;
	logic [DVD_W-1:0] mag;

	assign mag   = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
	assign trial = {rem_q, a_q[MAG_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mag[MAG_W-1:0];
			rem_q <= '0;
			d_q   <= divisor;
			neg_q <= dividend[DVD_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? DVR_W'(trial - {1'b0, d_q}) : trial[DVR_W-1:0];
			a_q   <= {a_q[MAG_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -signed'({1'b0, a_q}) : signed'({1'b0, a_q});

endmodule
`default_nettype wire

/* rtl/mvcb_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvcb_dp
// Datapath: item registers, shared divider, overlap and weight arithmetic,
// accumulator memories and the result register.
// ----------------------------------------------------------------------------
module mvcb_dp #(
	parameter int unsigned MAX_CELLS = 8192
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mvcb_pkg::cmd_t                   cmd,
	output mvcb_pkg::stat_t                       stat,
	input  wire logic [mvcb_pkg::IN_DATA_W-1:0]   in_data,
	input  wire logic [mvcb_pkg::CS_W-1:0]        cs,
	input  wire logic [mvcb_pkg::GRID_W-1:0]      gc,
	input  wire logic [mvcb_pkg::GRID_W-1:0]      gr,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [mvcb_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import mvcb_pkg::*;

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic signed [XY_W-1:0]  src_x, src_y, dst_x, dst_y;
	logic        [CN_W-1:0]  cell_number;
	logic signed [CRD_W-1:0] cs_s, bsx_q, bsy_q, mx_q, my_q;
	logic signed [CRD_W-1:0] c0_q, r0_q, c1_q, r1_q, row_q, col_q;
	logic        [CN_W-1:0]  n_q;
	logic        [AW-1:0]    clr_q;
	logic        [SUM_W-1:0] sum_x_q, sum_y_q;
	logic        [MEAN_W-1:0] mean_x_q, mean_y_q;
	logic                    out_v_q;
	logic        [OUT_DATA_W-1:0] out_q;

	// overlap stage
	logic        [15:0]      x0u, y0u;
	logic        [16:0]      x1u, y1u;
	logic signed [CRD_W-1:0] x0s, y0s, x1s, y1s, bex, bey;
	logic signed [CRD_W-1:0] ox0, oy0, ox1, oy1;
	logic signed [CRD_W-1:0] dw_s1, dh_s1;
	logic        [IDX_W-1:0] idx_s1;
	logic                    in_grid, in_grid_s1;
	logic signed [SUM_W-1:0] area_s2, mx32, my32, px_s3, py_s3;
	logic signed [2*CRD_W-1:0] area_full;

	// divider
	logic signed [DVD_W-1:0] dvd;
	logic        [DVR_W-1:0] dvr;
	logic                    div_done;
	logic signed [DVD_W-1:0] quo;

	// memory
	logic                    we;
	logic        [AW-1:0]    waddr, raddr;
	logic        [SUM_W-1:0] wdata_x, wdata_y, rdata_x, rdata_y;
	logic                    n_ok;

	assign src_x       = in_data[15:0];
	assign src_y       = in_data[31:16];
	assign dst_x       = in_data[47:32];
	assign dst_y       = in_data[63:48];
	assign cell_number = in_data[76:64];

	assign cs_s = signed'(CRD_W'(cs));
	assign bex  = bsx_q + cs_s;
	assign bey  = bsy_q + cs_s;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			bsx_q <= CRD_W'(dst_x) - CRD_W'(cs >> 1) - CRD_W'(1);
			bsy_q <= CRD_W'(dst_y) - CRD_W'(cs >> 1) - CRD_W'(1);
			mx_q  <= CRD_W'(dst_x) - CRD_W'(src_x);
			my_q  <= CRD_W'(dst_y) - CRD_W'(src_y);
			n_q   <= cell_number;
		end
	end

	// divider operand select
	always_comb begin
		case (cmd.dsel)
			DIV_C0:  dvd = DVD_W'(bsx_q);
			DIV_R0:  dvd = DVD_W'(bsy_q);
			DIV_C1:  dvd = DVD_W'(bex + cs_s - CRD_W'(1));
			DIV_R1:  dvd = DVD_W'(bey + cs_s - CRD_W'(1));
			DIV_MX:  dvd = DVD_W'(signed'(sum_x_q));
			DIV_MY:  dvd = DVD_W'(signed'(sum_y_q));
			default: dvd = '0;
		endcase
		if (cmd.dsel == DIV_MX || cmd.dsel == DIV_MY) begin
			dvr = DVR_W'(cs) * DVR_W'(cs);
		end else begin
			dvr = DVR_W'(cs);
		end
	end

	mvcb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (dvd),
		.divisor  (dvr),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV_WAIT && div_done) begin
			case (cmd.dsel)
				DIV_C0:  c0_q <= quo[CRD_W-1:0];
				DIV_R0:  r0_q <= quo[CRD_W-1:0];
				DIV_C1:  c1_q <= quo[CRD_W-1:0];
				DIV_R1:  r1_q <= quo[CRD_W-1:0];
				DIV_MX:  mean_x_q <= quo[MEAN_W-1:0];
				DIV_MY:  mean_y_q <= quo[MEAN_W-1:0];
				default: ;
			endcase
		end else if (cmd.op == OP_RZERO) begin
			mean_x_q <= '0;
			mean_y_q <= '0;
		end
		case (cmd.op)
			OP_ROW_INIT: row_q <= r0_q;
			OP_ROW_NEXT: row_q <= row_q + CRD_W'(1);
			OP_COL_INIT: col_q <= c0_q;
			OP_COL_NEXT: col_q <= col_q + CRD_W'(1);
			default: ;
		endcase
	end

	// overlap of the moved block with the current cell
	assign x0u = 16'(col_q[8:0]) * 16'(cs);
	assign y0u = 16'(row_q[8:0]) * 16'(cs);
	assign x1u = 17'(x0u) + 17'(cs);
	assign y1u = 17'(y0u) + 17'(cs);
	assign x0s = signed'(CRD_W'(x0u));
	assign y0s = signed'(CRD_W'(y0u));
	assign x1s = signed'(CRD_W'(x1u));
	assign y1s = signed'(CRD_W'(y1u));
	assign ox0 = (bsx_q > x0s) ? bsx_q : x0s;
	assign oy0 = (bsy_q > y0s) ? bsy_q : y0s;
	assign ox1 = (bex < x1s) ? bex : x1s;
	assign oy1 = (bey < y1s) ? bey : y1s;
	assign in_grid = !col_q[CRD_W-1] && (col_q < signed'(CRD_W'(gc)))
		&& !row_q[CRD_W-1] && (row_q < signed'(CRD_W'(gr)));

	assign area_full = dw_s1 * dh_s1;
	assign mx32      = SUM_W'(mx_q);
	assign my32      = SUM_W'(my_q);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OVL) begin
			dw_s1      <= ox1 - ox0;
			dh_s1      <= oy1 - oy0;
			idx_s1     <= IDX_W'(row_q[8:0]) * IDX_W'(gc) + IDX_W'(col_q[8:0]);
			in_grid_s1 <= in_grid;
		end
		if (cmd.op == OP_AREA) begin
			area_s2 <= area_full[SUM_W-1:0];
		end
		if (cmd.op == OP_MUL) begin
			px_s3 <= mx32 * area_s2;
			py_s3 <= my32 * area_s2;
		end
		if (cmd.op == OP_RCAP) begin
			sum_x_q <= rdata_x;
			sum_y_q <= rdata_y;
		end
	end

	// accumulator memories
	assign n_ok  = {{(32 - CN_W){1'b0}}, n_q} < 32'(MAX_CELLS);
	assign raddr = (cmd.op == OP_RRD) ? AW'(n_q) : idx_s1[AW-1:0];

	always_comb begin
		we      = 1'b0;
		waddr   = idx_s1[AW-1:0];
		wdata_x = '0;
		wdata_y = '0;
		case (cmd.op)
			OP_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			OP_MWR: begin
				we      = 1'b1;
				wdata_x = rdata_x + px_s3;
				wdata_y = rdata_y + py_s3;
			end
			OP_RCAP: begin
				we    = n_ok;
				waddr = AW'(n_q);
			end
			default: ;
		endcase
	end

	mvcb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CELLS)) u_ram_x (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata_x),
		.raddr (raddr),
		.rdata (rdata_x)
	);

	mvcb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CELLS)) u_ram_y (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata_y),
		.raddr (raddr),
		.rdata (rdata_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.op == OP_OUT) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_q <= {mean_y_q, mean_x_q};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	assign stat.clr_last = clr_q == AW'(MAX_CELLS - 1);
	assign stat.div_done = div_done;
	assign stat.row_lt   = row_q < r1_q;
	assign stat.col_lt   = col_q < c1_q;
	assign stat.cell_ok  = in_grid_s1 && (32'(idx_s1) < 32'(MAX_CELLS));
	assign stat.n_ok     = n_ok;
	assign stat.cs_zero  = cs == '0;
	assign stat.out_free = !out_v_q || m_tready;

endmodule
`default_nettype wire

/* rtl/mvcb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvcb_ctrl
// Controller: clearing pass, divisions, the row and column walk over the
// covered cells and the read-out sequence.
// ----------------------------------------------------------------------------
module mvcb_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic            s_tuser,
	input  wire mvcb_pkg::stat_t stat,
	output mvcb_pkg::cmd_t       cmd
);
	import mvcb_pkg::*;

	state_t   state_q, state_n;
	div_sel_t dsel_q, dsel_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			dsel_q  <= DIV_C0;
		end else begin
			state_q <= state_n;
			dsel_q  <= dsel_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		dsel_n   = dsel_q;
		cmd.op   = OP_NONE;
		cmd.dsel = dsel_q;
		s_tready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					if (s_tuser) begin
						state_n = S_RRD;
					end else if (!stat.cs_zero) begin
						dsel_n  = DIV_C0;
						state_n = S_DSTART;
					end
				end
			end
			S_DSTART: begin
				cmd.op  = OP_DIV_START;
				state_n = S_DWAIT;
			end
			S_DWAIT: begin
				cmd.op = OP_DIV_WAIT;
				if (stat.div_done) begin
					case (dsel_q)
						DIV_R1:  state_n = S_ROW_INIT;
						DIV_MY:  state_n = S_OUT;
						default: begin
							dsel_n  = div_sel_t'(dsel_q + 1'b1);
							state_n = S_DSTART;
						end
					endcase
				end
			end
			S_ROW_INIT: begin
				cmd.op  = OP_ROW_INIT;
				state_n = S_ROW_CHK;
			end
			S_ROW_CHK: begin
				state_n = stat.row_lt ? S_COL_INIT : S_IDLE;
			end
			S_COL_INIT: begin
				cmd.op  = OP_COL_INIT;
				state_n = S_COL_CHK;
			end
			S_COL_CHK: begin
				state_n = stat.col_lt ? S_OVL : S_ROW_NEXT;
			end
			S_OVL: begin
				cmd.op  = OP_OVL;
				state_n = S_AREA;
			end
			S_AREA: begin
				cmd.op  = OP_AREA;
				state_n = stat.cell_ok ? S_MUL : S_COL_NEXT;
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_n = S_MRD;
			end
			S_MRD: begin
				cmd.op  = OP_MRD;
				state_n = S_MWR;
			end
			S_MWR: begin
				cmd.op  = OP_MWR;
				state_n = S_COL_NEXT;
			end
			S_COL_NEXT: begin
				cmd.op  = OP_COL_NEXT;
				state_n = S_COL_CHK;
			end
			S_ROW_NEXT: begin
				cmd.op  = OP_ROW_NEXT;
				state_n = S_ROW_CHK;
			end
			S_RRD: begin
				cmd.op  = OP_RRD;
				state_n = S_RCAP;
			end
			S_RCAP: begin
				cmd.op = OP_RCAP;
				if (stat.n_ok && !stat.cs_zero) begin
					dsel_n  = DIV_MX;
					state_n = S_DSTART;
				end else begin
					state_n = S_RZERO;
				end
			end
			S_RZERO: begin
				cmd.op  = OP_RZERO;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire
